@@ hw/rtl/rbs_pkg.sv @@
// -----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for roi background subtraction
// Frame geometry, item layouts, register indexes and command codes.
// -----------------------------------------------------------------------------
package rbs_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 512;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;

   localparam int PIX_W   = 8;
   localparam int THR_W   = 8;
   localparam int WGT_W   = 9;
   localparam int COLS_W  = 11;
   localparam int ROWS_W  = 10;
   localparam int BROW_W  = 9;
   localparam int BOUND_W = 11;
   localparam int CSR_W   = 11;

   localparam logic [WGT_W-1:0]  WEIGHT_FULL  = WGT_W'(256);
   localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(30);
   localparam logic [WGT_W-1:0]  WGT_RESET    = WGT_W'(26);
   localparam logic [COLS_W-1:0] COLS_RESET   = COLS_W'(640);
   localparam logic [ROWS_W-1:0] ROWS_RESET   = ROWS_W'(480);

   typedef enum logic {
      CMD_PIXEL  = 1'b0,
      CMD_BOUNDS = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DIFF_THRESHOLD   = 2'd0,
      CSR_UPDATE_WEIGHT_Q8 = 2'd1,
      CSR_FRAME_COLUMNS    = 2'd2,
      CSR_FRAME_ROWS       = 2'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type              command;
      logic [PIX_W-1:0]     pixel;
      logic                 frame_start;
      logic [BROW_W-1:0]    bound_row;
      logic [BOUND_W-1:0]   bound_left;
      logic [BOUND_W-1:0]   bound_right;
   } req_type;

   typedef struct packed {
      logic                 is_background;
      logic [PIX_W-1:0]     background_level;
      logic                 frame_last;
   } rsp_type;

   typedef struct packed {
      logic [BOUND_W-1:0]   right;
      logic [BOUND_W-1:0]   left;
   } bounds_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    addr;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic                 last;
      logic                 learning;
   } scan_type;

   typedef struct packed {
      logic                 is_background;
      logic [PIX_W-1:0]     level;
      logic                 write;
   } upd_type;

endpackage

@@ hw/rtl/roi_background_subtraction.sv @@
// -----------------------------------------------------------------------------
// roi_background_subtraction: region-of-interest background subtraction
// Classifies a raster stream of gray pixels against a learned background.
// -----------------------------------------------------------------------------
// Usage:
//   req channel carries items in raster order: a pixel item (command pixel)
//   yields one rsp item, a bounds item (command bounds) loads the region of
//   one row and yields nothing.
//   csr port writes threshold, weight and frame size; write only while idle.
//   A pixel item passes the update stage and then the output register before
//   its result is valid on rsp.
//   Throughput: one item per cycle while rsp_ready holds high; the background
//   store has one read and one write port, a write from the update stage is
//   forwarded to a read of the same address issued in the same cycle.
//   When rsp_ready is low the result waits in the output register, one more
//   item waits in the update stage and req_ready then drops.
//   Reset clears the raster counters and sets the learning flag: the first
//   frame after reset is written to the store and reported as background.
//   Store and region table are not cleared; a row must have bounds loaded
//   before its first pixel after learning.
// -----------------------------------------------------------------------------
module roi_background_subtraction import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [THR_W-1:0]  thr_ff;
   logic [WGT_W-1:0]  wgt_ff;
   logic [COLS_W-1:0] cols_ff;
   logic [ROWS_W-1:0] rows_ff;

   logic              pixel_accept, bounds_accept, bounds_ok;
   logic              s1_advance;
   scan_type          scan;
   bounds_type        roi_rd, roi_wr;
   logic [PIX_W-1:0]  bg_rd;
   upd_type           upd;

   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_last_ff;
   logic              s1_learning_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         wgt_ff  <= WGT_RESET;
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIFF_THRESHOLD:   thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_UPDATE_WEIGHT_Q8: wgt_ff  <= csr_wdata[WGT_W-1:0];
            CSR_FRAME_COLUMNS:    cols_ff <= csr_wdata[COLS_W-1:0];
            CSR_FRAME_ROWS:       rows_ff <= csr_wdata[ROWS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready     = !s1_valid_ff || s1_advance;
   assign pixel_accept  = req_valid && req_ready && (req_data.command == CMD_PIXEL);
   assign bounds_accept = req_valid && req_ready && (req_data.command == CMD_BOUNDS);
   assign bounds_ok     = 32'(req_data.bound_row) < MAX_ROWS;

   assign roi_wr.left  = req_data.bound_left;
   assign roi_wr.right = req_data.bound_right;

   rbs_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .advance       (pixel_accept),
      .frame_start   (req_data.frame_start),
      .frame_columns (cols_ff),
      .frame_rows    (rows_ff),
      .scan          (scan)
   );

   rbs_roi_table u_roi_table (
      .clock   (clock),
      .wr_en   (bounds_accept && bounds_ok),
      .wr_row  (ROW_W'(req_data.bound_row)),
      .wr_data (roi_wr),
      .rd_en   (pixel_accept),
      .rd_row  (scan.row),
      .rd_data (roi_rd)
   );

   rbs_bg_store u_bg_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_advance && upd.write),
      .wr_addr (s1_addr_ff),
      .wr_data (upd.level),
      .rd_en   (pixel_accept),
      .rd_addr (scan.addr),
      .rd_data (bg_rd)
   );

   rbs_update u_update (
      .pixel            (s1_pixel_ff),
      .background       (bg_rd),
      .col              (s1_col_ff),
      .learning         (s1_learning_ff),
      .bounds           (roi_rd),
      .diff_threshold   (thr_ff),
      .update_weight_q8 (wgt_ff),
      .upd              (upd)
   );

   // update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pixel_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         s1_pixel_ff    <= req_data.pixel;
         s1_addr_ff     <= scan.addr;
         s1_col_ff      <= scan.col;
         s1_last_ff     <= scan.last;
         s1_learning_ff <= scan.learning;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff.is_background    <= upd.is_background;
         rsp_data_ff.background_level <= upd.level;
         rsp_data_ff.frame_last       <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("update stage dropped a pending item");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("result register not loaded after update stage moved on");

   a_learning_once: assert property (@(posedge clock) disable iff (reset)
      !scan.learning |=> !scan.learning)
      else $error("learning flag set again outside reset");

   a_write_from_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && upd.write) |-> s1_valid_ff && (s1_learning_ff || upd.is_background))
      else $error("store written without a valid background item");
`endif

endmodule

@@ hw/rtl/rbs_scan.sv @@
// -----------------------------------------------------------------------------
// rbs_scan: raster position tracking
// Column and row counters, store address, last-pixel flag and learning flag.
// -----------------------------------------------------------------------------
module rbs_scan import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               frame_start,
   input  logic [COLS_W-1:0]  frame_columns,
   input  logic [ROWS_W-1:0]  frame_rows,
   output scan_type           scan
);

   logic [COL_W-1:0]  col_ff, col_in, col_use;
   logic [ROW_W-1:0]  row_ff, row_in, row_use;
   logic              learning_ff, learning_in;
   logic [COLS_W-1:0] cols_c, col_inc;
   logic [ROWS_W-1:0] rows_c, row_inc;
   logic              col_wrap, row_wrap;

   // saturate frame size to the supported range
   always_comb begin
      if (frame_columns == '0) begin
         cols_c = COLS_W'(1);
      end else if (frame_columns > COLS_W'(MAX_COLUMNS)) begin
         cols_c = COLS_W'(MAX_COLUMNS);
      end else begin
         cols_c = frame_columns;
      end
      if (frame_rows == '0) begin
         rows_c = ROWS_W'(1);
      end else if (frame_rows > ROWS_W'(MAX_ROWS)) begin
         rows_c = ROWS_W'(MAX_ROWS);
      end else begin
         rows_c = frame_rows;
      end
   end

   always_comb begin
      col_use  = frame_start ? '0 : col_ff;
      row_use  = frame_start ? '0 : row_ff;
      col_inc  = COLS_W'(col_use) + COLS_W'(1);
      row_inc  = ROWS_W'(row_use) + ROWS_W'(1);
      col_wrap = col_inc >= cols_c;
      row_wrap = row_inc >= rows_c;

      scan.addr     = {row_use, col_use};
      scan.row      = row_use;
      scan.col      = col_use;
      scan.last     = col_wrap && row_wrap;
      scan.learning = learning_ff;

      col_in      = col_ff;
      row_in      = row_ff;
      learning_in = learning_ff;
      if (advance) begin
         col_in = col_wrap ? '0 : col_inc[COL_W-1:0];
         row_in = row_use;
         if (col_wrap) begin
            row_in = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end
         if (scan.last) begin
            learning_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         learning_ff <= 1'b1;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         learning_ff <= learning_in;
      end
   end

endmodule

@@ hw/rtl/rbs_roi_table.sv @@
// -----------------------------------------------------------------------------
// rbs_roi_table: per-row region bounds
// One write port for bound loads, one registered read port for pixel items.
// -----------------------------------------------------------------------------
module rbs_roi_table import rbs_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ROW_W-1:0]  wr_row,
   input  bounds_type        wr_data,
   input  logic              rd_en,
   input  logic [ROW_W-1:0]  rd_row,
   output bounds_type        rd_data
);

   bounds_type mem_ff [MAX_ROWS];
   bounds_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_ff;

endmodule

@@ hw/rtl/rbs_bg_store.sv @@
// -----------------------------------------------------------------------------
// rbs_bg_store: background frame store
// Registered read with forwarding of a write to the address read in the same cycle.
// -----------------------------------------------------------------------------
module rbs_bg_store import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [PIX_W-1:0]   wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [PIX_W-1:0]   rd_data
);

   logic [PIX_W-1:0] mem_ff [STORE_DEPTH];
   logic [PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0] fwd_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff  <= mem_ff[rd_addr];
         fwd_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = hit_ff ? fwd_ff : rd_ff;

endmodule

@@ hw/rtl/rbs_update.sv @@
// -----------------------------------------------------------------------------
// rbs_update: pixel classification and running average
// Decides foreground or background and computes the new background level.
// -----------------------------------------------------------------------------
module rbs_update import rbs_pkg::*; (
   input  logic [PIX_W-1:0]  pixel,
   input  logic [PIX_W-1:0]  background,
   input  logic [COL_W-1:0]  col,
   input  logic              learning,
   input  bounds_type        bounds,
   input  logic [THR_W-1:0]  diff_threshold,
   input  logic [WGT_W-1:0]  update_weight_q8,
   output upd_type           upd
);

   logic                      in_region;
   logic [PIX_W-1:0]          abs_diff;
   logic [WGT_W-1:0]          weight;
   logic signed [PIX_W:0]     delta;
   logic signed [PIX_W+WGT_W+1:0] prod;
   logic signed [PIX_W+2:0]   level_sum;

   always_comb begin
      in_region = (BOUND_W'(col) >= bounds.left) && (BOUND_W'(col) < bounds.right);
      abs_diff  = (pixel > background) ? pixel - background : background - pixel;
      weight    = (update_weight_q8 > WEIGHT_FULL) ? WEIGHT_FULL : update_weight_q8;
      delta     = $signed({1'b0, pixel}) - $signed({1'b0, background});
      prod      = delta * $signed({1'b0, weight});
      // floor(((256 - w) * bg + w * pix) / 256) == bg + floor(w * (pix - bg) / 256)
      level_sum = $signed({3'b000, background}) + prod[PIX_W+WGT_W+1:8];

      upd.is_background = 1'b1;
      upd.level         = background;
      upd.write         = 1'b0;
      if (learning) begin
         upd.level = pixel;
         upd.write = 1'b1;
      end else if (in_region) begin
         if (abs_diff > diff_threshold) begin
            upd.is_background = 1'b0;
         end else begin
            upd.level = level_sum[PIX_W-1:0];
            upd.write = 1'b1;
         end
      end
   end

endmodule

@@ tb/roi_background_subtraction_tb.sv @@
// -----------------------------------------------------------------------------
// roi_background_subtraction_tb: self-checking bench for roi background subtraction
// Learns a background frame over the top rows and the first column, then
// drives directed region, threshold and weight cases and a random pixel stream
// under changing frame geometry. Every result is checked against a behavioural
// model of the store, the region table and the raster counters.
// -----------------------------------------------------------------------------
module roi_background_subtraction_tb;
   import rbs_pkg::*;

   localparam int LEARN_COLS = 32;
   localparam int LEARN_ROWS = 24;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   roi_background_subtraction i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the block
   logic [PIX_W-1:0]   bg_level   [STORE_DEPTH];
   bit                 store_set  [STORE_DEPTH];
   bounds_type         row_bounds [MAX_ROWS];
   bit                 bounds_set [MAX_ROWS];
   int unsigned        row_cnt  = 0;
   int unsigned        col_cnt  = 0;
   bit                 learning = 1'b1;
   logic [THR_W-1:0]   thr_cfg  = THR_RESET;
   logic [WGT_W-1:0]   wgt_cfg  = WGT_RESET;
   logic [COLS_W-1:0]  cols_cfg = COLS_RESET;
   logic [ROWS_W-1:0]  rows_cfg = ROWS_RESET;

   rsp_type            expected_pixels [$];
   int unsigned        err_count  = 0;
   bit                 calm       = 1'b0;
   int unsigned        stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned size_in_use(input int unsigned v, input int unsigned limit);
      if (v < 1) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic void subtract_background(input req_type item);
      int unsigned cols, rows, addr, bg, w, diff;
      bit fg, last;
      rsp_type res;
      if (item.command == CMD_BOUNDS) begin
         row_bounds[item.bound_row].left  = item.bound_left;
         row_bounds[item.bound_row].right = item.bound_right;
         bounds_set[item.bound_row] = 1'b1;
         return;
      end
      cols = size_in_use(cols_cfg, MAX_COLUMNS);
      rows = size_in_use(rows_cfg, MAX_ROWS);
      if (item.frame_start) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      addr = row_cnt * MAX_COLUMNS + col_cnt;
      last = (col_cnt + 1 >= cols) && (row_cnt + 1 >= rows);
      fg = 1'b0;
      if (learning) begin
         bg = item.pixel;
         bg_level[addr] = item.pixel;
         store_set[addr] = 1'b1;
         if (last) learning = 1'b0;
      end else begin
         bg = bg_level[addr];
         if (col_cnt >= row_bounds[row_cnt].left && col_cnt < row_bounds[row_cnt].right) begin
            diff = (item.pixel > bg) ? item.pixel - bg : bg - item.pixel;
            if (diff > thr_cfg) begin
               fg = 1'b1;
            end else begin
               w = (wgt_cfg > WEIGHT_FULL) ? WEIGHT_FULL : wgt_cfg;
               bg = ((256 - w) * bg + w * item.pixel) >> 8;
               bg_level[addr] = PIX_W'(bg);
            end
         end
      end
      res.is_background    = !fg;
      res.background_level = PIX_W'(bg);
      res.frame_last       = last;
      expected_pixels.push_back(res);
      col_cnt++;
      if (col_cnt >= cols) begin
         col_cnt = 0;
         row_cnt++;
         if (row_cnt >= rows) row_cnt = 0;
      end
   endfunction

   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // mostly close to the stored background so both classes and updates occur
   function automatic logic [PIX_W-1:0] pick_level(input int unsigned addr);
      int unsigned r;
      int lvl, span;
      r = $urandom_range(0, 99);
      if (learning || !store_set[addr] || r >= 70) return PIX_W'($urandom_range(0, 255));
      if (r < 15) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      span = int'(thr_cfg) + 2;
      lvl = int'(bg_level[addr]) - span + int'($urandom_range(0, 2 * span));
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      return PIX_W'(lvl);
   endfunction

   function automatic req_type random_req();
      req_type item;
      item.command     = CMD_PIXEL;
      item.pixel       = PIX_W'($urandom_range(0, 255));
      item.frame_start = 1'($urandom_range(0, 1));
      item.bound_row   = BROW_W'($urandom_range(0, MAX_ROWS - 1));
      item.bound_left  = BOUND_W'($urandom_range(0, MAX_COLUMNS));
      item.bound_right = BOUND_W'($urandom_range(0, MAX_COLUMNS));
      return item;
   endfunction

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
         rsp_ready <= 1'b0;
         stall_left = pick_pause() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t result with none expected: %h", $time, rsp_data);
            err_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (want.is_background !== rsp_data.is_background) begin
               $display("%0t is_background: expected %0d, actual %0d", $time,
                        want.is_background, rsp_data.is_background);
               err_count++;
            end
            if (want.background_level !== rsp_data.background_level) begin
               $display("%0t background_level: expected %0d, actual %0d", $time,
                        want.background_level, rsp_data.background_level);
               err_count++;
            end
            if (want.frame_last !== rsp_data.frame_last) begin
               $display("%0t frame_last: expected %0d, actual %0d", $time,
                        want.frame_last, rsp_data.frame_last);
               err_count++;
            end
         end
      end
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = (!calm && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      subtract_background(item);
   endtask

   task automatic send_bounds(input int unsigned row, input int unsigned left,
                              input int unsigned right);
      req_type item;
      item = random_req();
      item.command     = CMD_BOUNDS;
      item.bound_row   = BROW_W'(row);
      item.bound_left  = BOUND_W'(left);
      item.bound_right = BOUND_W'(right);
      send_item(item);
   endtask

   task automatic load_random_bounds(input int unsigned row);
      int unsigned left, right;
      left  = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, MAX_COLUMNS);
      right = ($urandom_range(0, 3) != 0) ? MAX_COLUMNS : $urandom_range(0, MAX_COLUMNS);
      send_bounds(row, left, right);
   endtask

   // restarts the frame where the next position was never learned, and
   // loads the bounds of a row before its first pixel after learning
   task automatic send_pixel(input bit fs, input int level);
      req_type item;
      int unsigned addr;
      if (!learning && !fs && !store_set[row_cnt * MAX_COLUMNS + col_cnt]) fs = 1'b1;
      if (!learning && !bounds_set[fs ? 0 : row_cnt]) load_random_bounds(fs ? 0 : row_cnt);
      addr = fs ? 0 : row_cnt * MAX_COLUMNS + col_cnt;
      item = random_req();
      item.command     = CMD_PIXEL;
      item.frame_start = fs;
      item.pixel       = (level < 0) ? pick_level(addr) : PIX_W'(level);
      send_item(item);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
   endtask

   // bounds items give no result, so allow the pipeline to empty as well
   task automatic settle();
      drain();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_DIFF_THRESHOLD:   thr_cfg  = THR_W'(value);
         CSR_UPDATE_WEIGHT_Q8: wgt_cfg  = WGT_W'(value);
         CSR_FRAME_COLUMNS:    cols_cfg = COLS_W'(value);
         CSR_FRAME_ROWS:       rows_cfg = ROWS_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int unsigned cols, input int unsigned rows);
      write_reg(CSR_FRAME_COLUMNS, cols);
      write_reg(CSR_FRAME_ROWS, rows);
   endtask

   task automatic set_update(input int unsigned thr, input int unsigned wgt);
      write_reg(CSR_DIFF_THRESHOLD, thr);
      write_reg(CSR_UPDATE_WEIGHT_Q8, wgt);
   endtask

   // learned area: rows 0 and 1 up to the learned width, column 0 of the learned rows
   task automatic test_learning_frame();
      set_geometry(LEARN_COLS, LEARN_ROWS);
      send_pixel(1'b1, -1);
      repeat (2 * LEARN_COLS - 1) send_pixel(1'b0, -1);
      settle();
      write_reg(CSR_FRAME_COLUMNS, 1);
      repeat (LEARN_ROWS - 2) send_pixel(1'b0, -1);
   endtask

   task automatic test_region_directed();
      settle();
      set_geometry(4, 2);
      set_update(30, WEIGHT_FULL);
      send_bounds(0, 0, MAX_COLUMNS);
      send_bounds(1, 3, 1);
      send_pixel(1'b1, 0);
      send_pixel(1'b0, 255);
      send_pixel(1'b0, -1);
      send_pixel(1'b0, -1);
      send_pixel(1'b0, 255);
      send_pixel(1'b0, 0);
      send_pixel(1'b1, -1);
      send_pixel(1'b0, -1);
      send_bounds(0, MAX_COLUMNS, MAX_COLUMNS);
      send_bounds(1, 1, 4);
      repeat (4) send_pixel(1'b0, -1);
      settle();
      set_update(255, 511);
      send_bounds(0, 0, MAX_COLUMNS);
      send_pixel(1'b1, 255);
      send_pixel(1'b0, 0);
      settle();
      set_update(0, 0);
      send_pixel(1'b1, -1);
      send_pixel(1'b0, -1);
      send_pixel(1'b0, 255);
      send_pixel(1'b0, 0);
   endtask

   task automatic test_random_stream();
      int unsigned phase, sent, n, r, cols, rows, thr, wgt;
      phase = 0;
      sent  = 0;
      while (sent < 360) begin
         settle();
         case (phase)
            0: begin cols = 0;    rows = 0;    end
            1: begin cols = 2047; rows = 1;    end
            2: begin cols = 1;    rows = 1023; end
            3: begin cols = 1024; rows = 2;    end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 35) begin
                  cols = $urandom_range(0, 12);
                  rows = $urandom_range(0, 2);
               end else if (r < 70) begin
                  cols = $urandom_range(0, 1);
                  rows = $urandom_range(0, 12);
               end else if (r < 85) begin
                  cols = $urandom_range(0, 2047);
                  rows = $urandom_range(0, 2);
               end else begin
                  cols = $urandom_range(0, 1);
                  rows = $urandom_range(0, 1023);
               end
            end
         endcase
         r = $urandom_range(0, 9);
         thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 60);
         r = $urandom_range(0, 9);
         wgt = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? $urandom_range(257, 511) :
               $urandom_range(1, 255);
         set_geometry(cols, rows);
         set_update(thr, wgt);
         calm = ($urandom_range(0, 4) == 0);
         n = $urandom_range(20, 60);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               drain();
            end else begin
               if (r < 7)
                  load_random_bounds($urandom_range(0, MAX_ROWS - 1));
               else if (r < 12)
                  send_pixel(1'($urandom_range(0, 1)), -1);
               else
                  send_pixel(row_cnt == 0 && col_cnt == 0, -1);
               sent++;
            end
         end
         phase++;
      end
      calm = 1'b0;
   endtask

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_DIFF_THRESHOLD;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_learning_frame();
      test_region_directed();
      test_random_stream();
      settle();
      repeat (8) @(negedge clock);
      if (expected_pixels.size() != 0) err_count++;
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
